@@ src/layer_rotate_clip_center_crop_macros.svh @@
// Assertion macros shared by the layer clip and crop RTL.
`ifndef LAYER_ROTATE_CLIP_CENTER_CROP_MACROS_SVH
`define LAYER_ROTATE_CLIP_CENTER_CROP_MACROS_SVH

// Checked only while out of reset.
`define LRCC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define LRCC_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/lrcc_pkg.sv @@
// Shared constants and types for the layer rotate, clip and center crop block.
package lrcc_pkg;

    localparam int DIM_W          = 14;
    localparam int PROD_W         = 2 * DIM_W;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = DIM_W / BITS_PER_STAGE;
    localparam int CFG_ADDR_W     = 2;

    localparam logic [DIM_W-1:0] DIM_MAX = '1;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_W   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_H   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_ROT = 2'd2;

    localparam logic [DIM_W-1:0] RST_SCREEN_W = 14'd1920;
    localparam logic [DIM_W-1:0] RST_SCREEN_H = 14'd1080;

endpackage

@@ src/lrcc_div_pipe.sv @@
// Pipelined restoring divider: quotient known to fit in DIM_W bits, two bits per stage.
module lrcc_div_pipe (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [lrcc_pkg::PROD_W-1:0] i_num,
    input  logic [lrcc_pkg::DIM_W-1:0]  i_den,
    output logic [lrcc_pkg::DIM_W-1:0]  o_quo
);
    import lrcc_pkg::*;

    logic [PROD_W-1:0] r_rem [DIV_STAGES-1];
    logic [DIM_W-1:0]  r_den [DIV_STAGES-1];
    logic [DIM_W-1:0]  r_quo [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stg
        logic [PROD_W-1:0] rem_in;
        logic [PROD_W-1:0] n_rem;
        logic [DIM_W-1:0]  den_in;
        logic [DIM_W-1:0]  quo_in;
        logic [DIM_W-1:0]  n_quo;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        always_comb begin
            n_rem = rem_in;
            n_quo = quo_in;
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
                if (n_rem >= (PROD_W'(den_in) << (DIM_W - 1 - s * BITS_PER_STAGE - j))) begin
                    n_rem = n_rem - (PROD_W'(den_in) << (DIM_W - 1 - s * BITS_PER_STAGE - j));
                    n_quo[DIM_W - 1 - s * BITS_PER_STAGE - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s] <= n_quo;
            end
        end

        if (s < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_den[s] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

@@ src/layer_rotate_clip_center_crop.sv @@
// Top level: rotate a layer rectangle, clip it to the panel, center crop the source.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | i_valid / o_ready, i_dest_* i_source_*    | in
//          | i_scale_crop                              |
//  output  | o_valid / i_ready, o_out_dest_* o_out_source_* | out
//  config  | i_cfg_we, i_cfg_addr, i_cfg_wdata         | in
//
// One item per cycle while the output accepts; the pipeline runs through two banks of pipelined
// dividers (four for clip scaling, then one for center crop).
// Synchronous active-low reset empties the pipeline and loads the panel defaults.
// The whole pipeline advances together; a stall at the output freezes every stage.
`include "layer_rotate_clip_center_crop_macros.svh"

module layer_rotate_clip_center_crop #(
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lrcc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [lrcc_pkg::DIM_W-1:0]          i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COORD_BITS-1:0]        i_dest_x,
    input  logic signed [COORD_BITS-1:0]        i_dest_y,
    input  logic [lrcc_pkg::DIM_W-1:0]          i_dest_w,
    input  logic [lrcc_pkg::DIM_W-1:0]          i_dest_h,
    input  logic [lrcc_pkg::DIM_W-1:0]          i_source_x,
    input  logic [lrcc_pkg::DIM_W-1:0]          i_source_y,
    input  logic [lrcc_pkg::DIM_W-1:0]          i_source_w,
    input  logic [lrcc_pkg::DIM_W-1:0]          i_source_h,
    input  logic                                i_scale_crop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [COORD_BITS-1:0]        o_out_dest_x,
    output logic signed [COORD_BITS-1:0]        o_out_dest_y,
    output logic [lrcc_pkg::DIM_W-1:0]          o_out_dest_w,
    output logic [lrcc_pkg::DIM_W-1:0]          o_out_dest_h,
    output logic [lrcc_pkg::DIM_W-1:0]          o_out_source_x,
    output logic [lrcc_pkg::DIM_W-1:0]          o_out_source_y,
    output logic [lrcc_pkg::DIM_W-1:0]          o_out_source_w,
    output logic [lrcc_pkg::DIM_W-1:0]          o_out_source_h
);
    import lrcc_pkg::*;

    // wide enough for rotated edges and edge + size
    localparam int XW  = ((COORD_BITS > DIM_W + 2) ? COORD_BITS : DIM_W + 2) + 2;
    localparam int NST = 2 * DIV_STAGES + 7;
    localparam int ST_P1 = 0;
    localparam int ST_P4 = DIV_STAGES + 3;
    localparam int ST_D2 = DIV_STAGES + 6;

    localparam logic signed [XW-1:0] CMAX = $signed(XW'(2**(COORD_BITS-1) - 1));
    localparam logic signed [XW-1:0] CMIN = -CMAX - $signed(XW'(1));

    typedef struct packed {
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic [DIM_W-1:0]     dw;
        logic [DIM_W-1:0]     dh;
        logic [DIM_W-1:0]     sx;
        logic [DIM_W-1:0]     sy;
        logic [DIM_W-1:0]     sw;
        logic [DIM_W-1:0]     sh;
        logic                 crop;
    } t_rect;

    typedef struct packed {
        t_rect            r;
        logic [DIM_W-1:0] l;
        logic [DIM_W-1:0] t;
        logic [DIM_W-1:0] cw;
        logic [DIM_W-1:0] ch;
        logic             empty;
        logic             unch;
    } t_clip;

    typedef struct packed {
        t_rect r;
        logic  gt;
        logic  lt;
    } t_crop;

    // configuration
    logic [DIM_W-1:0] r_scr_w;
    logic [DIM_W-1:0] r_scr_h;
    t_rot             r_scr_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w   <= RST_SCREEN_W;
            r_scr_h   <= RST_SCREEN_H;
            r_scr_rot <= ROT_0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SCREEN_W:   r_scr_w   <= i_cfg_wdata;
                CFG_SCREEN_H:   r_scr_h   <= i_cfg_wdata;
                CFG_SCREEN_ROT: r_scr_rot <= t_rot'(i_cfg_wdata[1:0]);
                default: ;
            endcase
        end
    end

    logic signed [XW-1:0] ws;
    logic signed [XW-1:0] hs;
    assign ws = $signed(XW'(r_scr_w));
    assign hs = $signed(XW'(r_scr_h));

    // pipeline control
    logic            en;
    logic [NST-1:0]  r_vld;

    assign en      = !r_vld[NST-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid && o_ready};
        end
    end

    // P1: rotate into panel coordinates
    t_rect                n_r1;
    t_rect                r_r1;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] wd;
    logic signed [XW-1:0] hd;

    assign xs = XW'(i_dest_x);
    assign ys = XW'(i_dest_y);
    assign wd = $signed(XW'(i_dest_w));
    assign hd = $signed(XW'(i_dest_h));

    always_comb begin
        n_r1.sx   = i_source_x;
        n_r1.sy   = i_source_y;
        n_r1.sw   = i_source_w;
        n_r1.sh   = i_source_h;
        n_r1.crop = i_scale_crop;
        unique case (r_scr_rot)
            ROT_90: begin
                n_r1.dx = ys;
                n_r1.dy = hs - xs - wd;
                n_r1.dw = i_dest_h;
                n_r1.dh = i_dest_w;
            end
            ROT_180: begin
                n_r1.dx = ws - xs - wd;
                n_r1.dy = hs - ys - hd;
                n_r1.dw = i_dest_w;
                n_r1.dh = i_dest_h;
            end
            ROT_270: begin
                n_r1.dx = ws - ys - hd;
                n_r1.dy = xs;
                n_r1.dw = i_dest_h;
                n_r1.dh = i_dest_w;
            end
            default: begin
                n_r1.dx = xs;
                n_r1.dy = ys;
                n_r1.dw = i_dest_w;
                n_r1.dh = i_dest_h;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r1 <= n_r1;
        end
    end

    // P2: intersect with the panel
    t_clip                n_c2;
    t_clip                r_c2;
    logic [DIM_W-1:0]     n_offx;
    logic [DIM_W-1:0]     n_offy;
    logic [DIM_W-1:0]     r_offx;
    logic [DIM_W-1:0]     r_offy;
    logic signed [XW-1:0] dwx;
    logic signed [XW-1:0] dhx;
    logic signed [XW-1:0] lft;
    logic signed [XW-1:0] top;
    logic signed [XW-1:0] rgt;
    logic signed [XW-1:0] bot;
    logic signed [XW-1:0] cwx;
    logic signed [XW-1:0] chx;

    assign dwx = $signed(XW'(r_r1.dw));
    assign dhx = $signed(XW'(r_r1.dh));

    always_comb begin
        lft = (r_r1.dx > 0) ? r_r1.dx : '0;
        top = (r_r1.dy > 0) ? r_r1.dy : '0;
        rgt = ((r_r1.dx + dwx) < ws) ? (r_r1.dx + dwx) : ws;
        bot = ((r_r1.dy + dhx) < hs) ? (r_r1.dy + dhx) : hs;
        cwx = rgt - lft;
        chx = bot - top;
        n_c2.r     = r_r1;
        n_c2.empty = (cwx <= 0) || (chx <= 0);
        if (n_c2.empty) begin
            n_c2.unch = (r_r1.dx == 0) && (r_r1.dy == 0) && (r_r1.dw == '0) && (r_r1.dh == '0);
        end else begin
            n_c2.unch = (lft == r_r1.dx) && (top == r_r1.dy) && (cwx == dwx) && (chx == dhx);
        end
        // a non-empty clip keeps all of these below 2^14
        n_c2.l  = lft[DIM_W-1:0];
        n_c2.t  = top[DIM_W-1:0];
        n_c2.cw = cwx[DIM_W-1:0];
        n_c2.ch = chx[DIM_W-1:0];
        n_offx  = DIM_W'(lft - r_r1.dx);
        n_offy  = DIM_W'(top - r_r1.dy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c2   <= n_c2;
            r_offx <= n_offx;
            r_offy <= n_offy;
        end
    end

    // P3: products for the proportional source shrink
    t_clip             r_c3;
    logic [PROD_W-1:0] r_px;
    logic [PROD_W-1:0] r_py;
    logic [PROD_W-1:0] r_pw;
    logic [PROD_W-1:0] r_ph;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c3 <= r_c2;
            r_px <= PROD_W'(r_offx) * PROD_W'(r_c2.r.sw);
            r_py <= PROD_W'(r_offy) * PROD_W'(r_c2.r.sh);
            r_pw <= PROD_W'(r_c2.r.sw) * PROD_W'(r_c2.cw);
            r_ph <= PROD_W'(r_c2.r.sh) * PROD_W'(r_c2.ch);
        end
    end

    logic [DIM_W-1:0] q_sx;
    logic [DIM_W-1:0] q_sy;
    logic [DIM_W-1:0] q_sw;
    logic [DIM_W-1:0] q_sh;

    lrcc_div_pipe u_div_sx (.i_clk(i_clk), .i_en(en), .i_num(r_px), .i_den(r_c3.r.dw),
                            .o_quo(q_sx));
    lrcc_div_pipe u_div_sy (.i_clk(i_clk), .i_en(en), .i_num(r_py), .i_den(r_c3.r.dh),
                            .o_quo(q_sy));
    lrcc_div_pipe u_div_sw (.i_clk(i_clk), .i_en(en), .i_num(r_pw), .i_den(r_c3.r.dw),
                            .o_quo(q_sw));
    lrcc_div_pipe u_div_sh (.i_clk(i_clk), .i_en(en), .i_num(r_ph), .i_den(r_c3.r.dh),
                            .o_quo(q_sh));

    t_clip r_sd1 [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd1[0] <= r_c3;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_sd1[k] <= r_sd1[k-1];
            end
        end
    end

    // P4: pick clipped, zeroed or untouched rectangle
    t_clip r_cl;
    t_rect n_r4;
    t_rect r_r4;

    assign r_cl = r_sd1[DIV_STAGES-1];

    always_comb begin
        n_r4 = r_cl.r;
        if (!r_cl.unch) begin
            n_r4.dx = $signed(XW'(r_cl.l));
            n_r4.dy = $signed(XW'(r_cl.t));
            n_r4.dw = r_cl.cw;
            n_r4.dh = r_cl.ch;
            if (r_cl.empty) begin
                n_r4.dx = '0;
                n_r4.dy = '0;
                n_r4.dw = '0;
                n_r4.dh = '0;
                n_r4.sx = '0;
                n_r4.sy = '0;
                n_r4.sw = '0;
                n_r4.sh = '0;
            end else begin
                n_r4.sx = q_sx;
                n_r4.sy = q_sy;
                n_r4.sw = q_sw;
                n_r4.sh = q_sh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r4 <= n_r4;
        end
    end

    // P5: aspect cross products
    t_rect             r_r5;
    logic [PROD_W-1:0] r_a5;
    logic [PROD_W-1:0] r_b5;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r5 <= r_r4;
            r_a5 <= PROD_W'(r_r4.sw) * PROD_W'(r_r4.dh);
            r_b5 <= PROD_W'(r_r4.sh) * PROD_W'(r_r4.dw);
        end
    end

    // P6: compare, choose crop direction and divider operands
    t_crop             r_k6;
    logic [PROD_W-1:0] r_num6;
    logic [DIM_W-1:0]  r_den6;
    logic              gt6;

    assign gt6 = r_a5 > r_b5;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k6.r  <= r_r5;
            r_k6.gt <= r_r5.crop && gt6;
            r_k6.lt <= r_r5.crop && (r_a5 < r_b5);
            r_num6  <= gt6 ? r_b5 : r_a5;
            r_den6  <= gt6 ? r_r5.dh : r_r5.dw;
        end
    end

    logic [DIM_W-1:0] q_crop;

    lrcc_div_pipe u_div_crop (.i_clk(i_clk), .i_en(en), .i_num(r_num6), .i_den(r_den6),
                              .o_quo(q_crop));

    t_crop r_sd2 [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd2[0] <= r_k6;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_sd2[k] <= r_sd2[k-1];
            end
        end
    end

    // P7: apply the crop, saturate, output register
    t_crop                r_ck;
    logic [DIM_W:0]       pos_x;
    logic [DIM_W:0]       pos_y;
    logic signed [COORD_BITS-1:0] n_ox;
    logic signed [COORD_BITS-1:0] n_oy;
    logic [DIM_W-1:0]     n_osx;
    logic [DIM_W-1:0]     n_osy;
    logic [DIM_W-1:0]     n_osw;
    logic [DIM_W-1:0]     n_osh;

    assign r_ck = r_sd2[DIV_STAGES-1];

    always_comb begin
        pos_x = (DIM_W+1)'(r_ck.r.sx) + (DIM_W+1)'((r_ck.r.sw - q_crop) >> 1);
        pos_y = (DIM_W+1)'(r_ck.r.sy) + (DIM_W+1)'((r_ck.r.sh - q_crop) >> 1);
        n_osx = r_ck.r.sx;
        n_osy = r_ck.r.sy;
        n_osw = r_ck.r.sw;
        n_osh = r_ck.r.sh;
        if (r_ck.gt) begin
            n_osx = pos_x[DIM_W] ? DIM_MAX : pos_x[DIM_W-1:0];
            n_osw = q_crop;
        end else if (r_ck.lt) begin
            n_osy = pos_y[DIM_W] ? DIM_MAX : pos_y[DIM_W-1:0];
            n_osh = q_crop;
        end
        if (r_ck.r.dx > CMAX) begin
            n_ox = CMAX[COORD_BITS-1:0];
        end else if (r_ck.r.dx < CMIN) begin
            n_ox = CMIN[COORD_BITS-1:0];
        end else begin
            n_ox = r_ck.r.dx[COORD_BITS-1:0];
        end
        if (r_ck.r.dy > CMAX) begin
            n_oy = CMAX[COORD_BITS-1:0];
        end else if (r_ck.r.dy < CMIN) begin
            n_oy = CMIN[COORD_BITS-1:0];
        end else begin
            n_oy = r_ck.r.dy[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_dest_x   <= n_ox;
            o_out_dest_y   <= n_oy;
            o_out_dest_w   <= r_ck.r.dw;
            o_out_dest_h   <= r_ck.r.dh;
            o_out_source_x <= n_osx;
            o_out_source_y <= n_osy;
            o_out_source_w <= n_osw;
            o_out_source_h <= n_osh;
        end
    end

    `LRCC_ASSERT_ANY(a_rst_empty, !i_rst_n |=> (r_vld == '0), "pipeline holds items after reset")
    `LRCC_ASSERT_RST(a_stall_blocks, (o_valid && !i_ready) |-> !o_ready, "input taken while stalled")
    `LRCC_ASSERT_RST(a_enter, (i_valid && o_ready) |=> r_vld[ST_P1], "accepted item not in P1")
    `LRCC_ASSERT_RST(a_hold, !en |=> $stable(r_vld), "valid bits moved during a stall")
    `LRCC_ASSERT_RST(a_mid, (en && r_vld[ST_P4 - 1]) |=> r_vld[ST_P4], "item lost at clip divider")
    `LRCC_ASSERT_RST(a_crop, (en && r_vld[ST_D2 - 1]) |=> r_vld[ST_D2], "item lost at crop divider")

endmodule

@@ dv/layer_rotate_clip_center_crop_tb.sv @@
// Testbench for the layer rotate, clip and center crop block.
`timescale 1ns / 1ps

module layer_rotate_clip_center_crop_tb;
    import lrcc_pkg::*;

    localparam int CB = 16;
    localparam int LATENCY = 2 * DIV_STAGES + 7;
    localparam int N_RANDOM = 480;

    typedef struct packed {
        logic signed [CB-1:0] dx;
        logic signed [CB-1:0] dy;
        logic [DIM_W-1:0] dw;
        logic [DIM_W-1:0] dh;
        logic [DIM_W-1:0] sx;
        logic [DIM_W-1:0] sy;
        logic [DIM_W-1:0] sw;
        logic [DIM_W-1:0] sh;
    } t_rect_set;

    typedef struct {
        t_rect_set lay;
        logic crop;
        logic has_exp;
        t_rect_set exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [DIM_W-1:0] i_cfg_wdata = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [CB-1:0] i_dest_x = '0, i_dest_y = '0;
    logic [DIM_W-1:0] i_dest_w = '0, i_dest_h = '0;
    logic [DIM_W-1:0] i_source_x = '0, i_source_y = '0, i_source_w = '0, i_source_h = '0;
    logic i_scale_crop = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [CB-1:0] o_out_dest_x, o_out_dest_y;
    logic [DIM_W-1:0] o_out_dest_w, o_out_dest_h;
    logic [DIM_W-1:0] o_out_source_x, o_out_source_y, o_out_source_w, o_out_source_h;

    // panel model
    longint panel_w = 1920, panel_h = 1080;
    t_rot panel_rot = ROT_0;

    t_rect_set pending_layers[$];
    int errors = 0;
    int n_sent = 0, n_got = 0, n_crop = 0;
    bit sending_done = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    layer_rotate_clip_center_crop #(.COORD_BITS(CB)) u_dut (.*);

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_rect_set place_layer(t_rect_set a, logic crop);
        longint x, y, w, h, sx, sy, sw, sh, dx, dy, dw, dh;
        longint l, t, r, b, cw, ch, nw, nh;
        longint mn, mx;
        bit act;
        t_rect_set o;
        x = a.dx; y = a.dy; w = a.dw; h = a.dh;
        sx = a.sx; sy = a.sy; sw = a.sw; sh = a.sh;
        case (panel_rot)
            ROT_90:  begin dx = y; dy = panel_h - x - w; dw = h; dh = w; end
            ROT_180: begin dx = panel_w - x - w; dy = panel_h - y - h; dw = w; dh = h; end
            ROT_270: begin dx = panel_w - y - h; dy = x; dw = h; dh = w; end
            default: begin dx = x; dy = y; dw = w; dh = h; end
        endcase
        l = dx > 0 ? dx : 0;
        t = dy > 0 ? dy : 0;
        r = (dx + dw) < panel_w ? dx + dw : panel_w;
        b = (dy + dh) < panel_h ? dy + dh : panel_h;
        cw = r - l; ch = b - t;
        if (cw <= 0 || ch <= 0) begin l = 0; t = 0; cw = 0; ch = 0; end
        if (!(l == dx && t == dy && cw == dw && ch == dh)) begin
            if (cw == 0) begin
                sx = 0; sy = 0; sw = 0; sh = 0;
            end else begin
                sx = (l - dx) * sw / dw;
                sy = (t - dy) * sh / dh;
                sw = sw * cw / dw;
                sh = sh * ch / dh;
            end
            dx = l; dy = t; dw = cw; dh = ch;
        end
        if (crop) begin
            nw = sw; nh = sh; act = 1;
            if (nw * dh > nh * dw) nw = dw * nh / dh;
            else if (nw * dh < nh * dw) nh = dh * nw / dw;
            else act = 0;
            if (act) begin
                if (nw < sw) begin sx += (sw - nw) / 2; sw = nw; end
                else begin sy += (sh - nh) / 2; sh = nh; end
            end
        end
        mx = (64'sd1 << (CB - 1)) - 1;
        mn = -(64'sd1 << (CB - 1));
        o.dx = CB'(sat(dx, mn, mx)); o.dy = CB'(sat(dy, mn, mx));
        o.dw = DIM_W'(sat(dw, 0, 16383)); o.dh = DIM_W'(sat(dh, 0, 16383));
        o.sx = DIM_W'(sat(sx, 0, 16383)); o.sy = DIM_W'(sat(sy, 0, 16383));
        o.sw = DIM_W'(sat(sw, 0, 16383)); o.sh = DIM_W'(sat(sh, 0, 16383));
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d: %s got %0d expected %0d", n_got, what, got, want);
        errors++;
    endtask

    // output side: random stalls, compare at the rising edge
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_rect_set e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_layers.size() == 0) begin
                $display("unexpected result with nothing pending");
                errors++;
            end else begin
                e = pending_layers.pop_front();
                if (o_out_dest_x !== e.dx) report_mismatch("dest_x", o_out_dest_x, e.dx);
                if (o_out_dest_y !== e.dy) report_mismatch("dest_y", o_out_dest_y, e.dy);
                if (o_out_dest_w !== e.dw) report_mismatch("dest_w", o_out_dest_w, e.dw);
                if (o_out_dest_h !== e.dh) report_mismatch("dest_h", o_out_dest_h, e.dh);
                if (o_out_source_x !== e.sx) report_mismatch("src_x", o_out_source_x, e.sx);
                if (o_out_source_y !== e.sy) report_mismatch("src_y", o_out_source_y, e.sy);
                if (o_out_source_w !== e.sw) report_mismatch("src_w", o_out_source_w, e.sw);
                if (o_out_source_h !== e.sh) report_mismatch("src_h", o_out_source_h, e.sh);
            end
            n_got++;
        end
    end

    task automatic send_layer(t_rect_set a, logic crop);
        int gap;
        if ($urandom_range(0, 2) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_dest_x <= a.dx; i_dest_y <= a.dy; i_dest_w <= a.dw; i_dest_h <= a.dh;
        i_source_x <= a.sx; i_source_y <= a.sy; i_source_w <= a.sw; i_source_h <= a.sh;
        i_scale_crop <= crop;
        do @(posedge i_clk); while (!o_ready);
        pending_layers.push_back(place_layer(a, crop));
        n_sent++;
        n_crop += crop;
        @(negedge i_clk);
    endtask

    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (pending_layers.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // dropping the write enable after each write keeps back-to-back writes apart
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [DIM_W-1:0] v);
        i_cfg_we <= 1'b1; i_cfg_addr <= idx; i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SCREEN_W: panel_w = v;
            CFG_SCREEN_H: panel_h = v;
            CFG_SCREEN_ROT: panel_rot = t_rot'(v[1:0]);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function automatic t_rect_set random_layer();
        t_rect_set a;
        int m;
        m = $urandom_range(0, 9);
        a.dx = (m < 6) ? CB'($signed($urandom_range(0, 600)) - 100) : CB'($urandom);
        a.dy = (m < 6) ? CB'($signed($urandom_range(0, 600)) - 100) : CB'($urandom);
        a.dw = (m < 6) ? DIM_W'($urandom_range(0, 700)) : DIM_W'($urandom);
        a.dh = (m < 6) ? DIM_W'($urandom_range(0, 700)) : DIM_W'($urandom);
        a.sx = DIM_W'($urandom);
        a.sy = DIM_W'($urandom);
        a.sw = (m < 8) ? DIM_W'($urandom_range(0, 4000)) : DIM_W'($urandom);
        a.sh = (m < 8) ? DIM_W'($urandom_range(0, 4000)) : DIM_W'($urandom);
        return a;
    endfunction

    t_row dir_rows[$];

    function automatic t_row mk(int x, int y, int w, int h, int sx, int sy, int sw, int sh,
                                bit c);
        t_row r;
        r.lay = '{CB'(x), CB'(y), DIM_W'(w), DIM_W'(h),
                  DIM_W'(sx), DIM_W'(sy), DIM_W'(sw), DIM_W'(sh)};
        r.crop = c;
        r.has_exp = 0;
        r.exp = '0;
        return r;
    endfunction

    initial begin
        t_row r;
        int cfg_w[4] = '{8192, 1, 640, 8192};
        int cfg_h[4] = '{8192, 1, 480, 1};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset panel (1920x1080, no rotation)
        r = mk(0, 0, 0, 0, 5, 6, 7, 8, 0);          // zero rectangle counts as unchanged
        r.has_exp = 1; r.exp = '{0, 0, 0, 0, 5, 6, 7, 8}; dir_rows.push_back(r);
        r = mk(100, 100, 0, 50, 5, 6, 7, 8, 1);     // empty intersection clears source
        r.has_exp = 1; r.exp = '{0, 0, 0, 0, 0, 0, 0, 0}; dir_rows.push_back(r);
        r = mk(-32768, -32768, 16383, 16383, 16383, 16383, 16383, 16383, 1);
        dir_rows.push_back(r);
        r = mk(32767, 32767, 16383, 16383, 0, 0, 16383, 16383, 0);
        r.has_exp = 1; r.exp = '{0, 0, 0, 0, 0, 0, 0, 0}; dir_rows.push_back(r);
        r = mk(10, 20, 300, 200, 1, 2, 300, 200, 1);  // aspect already equal
        r.has_exp = 1; r.exp = '{10, 20, 300, 200, 1, 2, 300, 200}; dir_rows.push_back(r);
        dir_rows.push_back(mk(0, 0, 400, 100, 0, 0, 400, 400, 1));   // source too tall
        dir_rows.push_back(mk(0, 0, 100, 400, 0, 0, 400, 400, 1));   // source too wide
        dir_rows.push_back(mk(-50, -30, 200, 100, 16000, 16000, 1000, 900, 0)); // clipped
        dir_rows.push_back(mk(1800, 1000, 400, 300, 7, 7, 4000, 3000, 1));
        dir_rows.push_back(mk(100, 100, 50, 50, 16383, 16383, 0, 40, 1)); // zero source w
        dir_rows.push_back(mk(-1, 0, 1, 1, 0, 0, 16383, 16383, 1));
        foreach (dir_rows[i]) begin
            if (dir_rows[i].has_exp && place_layer(dir_rows[i].lay, dir_rows[i].crop)
                    !== dir_rows[i].exp) begin
                $display("directed row %0d disagrees with typed value", i);
                errors++;
            end
            send_layer(dir_rows[i].lay, dir_rows[i].crop);
        end
        // each rotation with a few edge layers
        for (int k = 0; k < 4; k++) begin
            drain_pipe();
            write_reg(CFG_SCREEN_ROT, DIM_W'(k));
            r = mk(-10, 5, 300, 100, 3, 4, 900, 300, 1);
            send_layer(r.lay, 1);
            r = mk(1900, 1070, 100, 40, 9, 9, 500, 200, 0);
            send_layer(r.lay, 0);
        end

        // random part over several panel settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            drain_pipe();
            if (ph < 4) begin
                write_reg(CFG_SCREEN_W, DIM_W'(cfg_w[ph]));
                write_reg(CFG_SCREEN_H, DIM_W'(cfg_h[ph]));
            end else begin
                write_reg(CFG_SCREEN_W, DIM_W'($urandom_range(1, 16383)));
                write_reg(CFG_SCREEN_H, DIM_W'($urandom_range(1, 16383)));
            end
            write_reg(CFG_SCREEN_ROT, DIM_W'($urandom_range(0, 3)));
            for (int n = 0; n < N_RANDOM / 6; n++)
                send_layer(random_layer(), 1'($urandom));
        end
        drain_pipe();
        sending_done = 1;
    end

    initial begin
        wait (sending_done);
        $display("sent %0d layers (%0d with center crop), checked %0d results", n_sent,
                 n_crop, n_got);
        $display("covered all four rotations, panel sizes 1x1 to 8192x8192, and clipping");
        if (errors == 0 && pending_layers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
